FILE: design/rnsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnsm_pkg
// Shared types, constants and helpers of the rotation source address map.
// ----------------------------------------------------------------------------
package rnsm_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int FRACTION_BITS = 10;

  localparam int CoordW  = 12;
  localparam int DimW    = 13;
  localparam int TrigW   = 12;
  localparam int PitchW  = 15;
  localparam int OffsetW = 26;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 15;

  localparam int DeltaW  = CoordW + 1;
  localparam int ProdW   = DeltaW + TrigW;
  localparam int SumW    = ProdW + 1;
  localparam int RotW    = SumW - FRACTION_BITS;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SINE          = 3'd0,
    REG_COSINE        = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_DEST_WIDTH    = 3'd4,
    REG_DEST_HEIGHT   = 3'd5,
    REG_SOURCE_PITCH  = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] dest_col;
    logic [CoordW-1:0] dest_row;
  } in_beat_t;

  typedef struct packed {
    logic [CoordW-1:0]  src_col;
    logic [CoordW-1:0]  src_row;
    logic               inside_res;
    logic [OffsetW-1:0] src_byte_offset;
  } out_beat_t;

  typedef struct packed {
    logic signed [TrigW-1:0] sine;
    logic signed [TrigW-1:0] cosine;
    logic [CoordW-1:0]       src_half_w;
    logic [CoordW-1:0]       src_half_h;
    logic [CoordW-1:0]       dst_half_w;
    logic [CoordW-1:0]       dst_half_h;
    logic [PitchW-1:0]       pitch;
  } cfg_t;

  function automatic logic [CoordW-1:0] dim_half(input logic [DimW-1:0] v);
    logic [CoordW-1:0] h;
    if (int'(v) > MAX_DIM) begin
      h = CoordW'(MAX_DIM / 2);
    end else begin
      h = v[DimW-1:1];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: design/rotate_nearest_source_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_nearest_source_map
// Inverse-mapping source address generator for nearest-neighbor rotation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive start_i with a destination pixel on in_i; the beat is
//   taken on any edge where start_i is high and busy_o is low. busy_o is
//   never raised, so a new pixel can enter every cycle.
//   Result channel: res_valid_o strobes for one cycle with the source pixel,
//   inside flag and byte offset on res_o. Outside points read as all zero.
//   Throughput is one pixel per clock, set by a five-stage pipeline:
//   centering, four parallel multipliers, rotated sums, scale and bounds
//   test, then the row-times-pitch multiplier.
//   The receiver cannot stall; results appear in input order.
//   Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i;
//   write only while no pixel is in flight.
//   Reset: asynchronous, clears the pipeline valid bits and loads the
//   default registers (no rotation, 640 by 480, pitch 2560).
// ----------------------------------------------------------------------------
module rotate_nearest_source_map (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire rnsm_pkg::in_beat_t            in_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output rnsm_pkg::out_beat_t                res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rnsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rnsm_pkg::CfgW-1:0]     cfg_data_i
);

  rnsm_pkg::cfg_t                    cfg;
  logic                              accept;
  logic                              rot_valid;
  logic signed [rnsm_pkg::SumW-1:0]  rot_xs, rot_ys;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rnsm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rnsm_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .beat_i  (in_i),
    .cfg_i   (cfg),
    .valid_o (rot_valid),
    .xs_o    (rot_xs),
    .ys_o    (rot_ys)
  );

  rnsm_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .xs_i    (rot_xs),
    .ys_i    (rot_ys),
    .cfg_i   (cfg),
    .valid_o (res_valid_o),
    .beat_o  (res_o)
  );

  // every accepted beat comes out as a result at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 res_valid_o)
    else $error("accepted beat did not produce a result");

  // no result without an accepted beat at the head of the pipeline
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 5))
    else $error("result without an accepted beat");

  // outside points carry zero fields
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.inside_res) |->
      (res_o.src_col == '0 && res_o.src_row == '0 && res_o.src_byte_offset == '0))
    else $error("outside result has nonzero fields");

  // offset matches the reported coordinate
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.inside_res) |->
      (res_o.src_byte_offset == rnsm_pkg::OffsetW'(
        (rnsm_pkg::OffsetW'(res_o.src_row) * rnsm_pkg::OffsetW'(cfg.pitch)) +
        rnsm_pkg::OffsetW'({res_o.src_col, 2'b00}))))
    else $error("byte offset does not match coordinate");

endmodule
`default_nettype wire

FILE: design/rnsm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnsm_cfg
// Configuration register file with derived image centers.
// ----------------------------------------------------------------------------
module rnsm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rnsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rnsm_pkg::CfgW-1:0]     cfg_data_i,
  output rnsm_pkg::cfg_t                     cfg_o
);

  logic [rnsm_pkg::TrigW-1:0]  sine_q,  cosine_q;
  logic [rnsm_pkg::DimW-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [rnsm_pkg::PitchW-1:0] pitch_q;
  rnsm_pkg::cfg_reg_e          idx;

  assign idx = rnsm_pkg::cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q   <= '0;
      cosine_q <= rnsm_pkg::TrigW'(1024);
      src_w_q  <= rnsm_pkg::DimW'(640);
      src_h_q  <= rnsm_pkg::DimW'(480);
      dst_w_q  <= rnsm_pkg::DimW'(640);
      dst_h_q  <= rnsm_pkg::DimW'(480);
      pitch_q  <= rnsm_pkg::PitchW'(2560);
    end else if (cfg_we_i) begin
      case (idx)
        rnsm_pkg::REG_SINE:          sine_q   <= cfg_data_i[rnsm_pkg::TrigW-1:0];
        rnsm_pkg::REG_COSINE:        cosine_q <= cfg_data_i[rnsm_pkg::TrigW-1:0];
        rnsm_pkg::REG_SOURCE_WIDTH:  src_w_q  <= cfg_data_i[rnsm_pkg::DimW-1:0];
        rnsm_pkg::REG_SOURCE_HEIGHT: src_h_q  <= cfg_data_i[rnsm_pkg::DimW-1:0];
        rnsm_pkg::REG_DEST_WIDTH:    dst_w_q  <= cfg_data_i[rnsm_pkg::DimW-1:0];
        rnsm_pkg::REG_DEST_HEIGHT:   dst_h_q  <= cfg_data_i[rnsm_pkg::DimW-1:0];
        rnsm_pkg::REG_SOURCE_PITCH:  pitch_q  <= cfg_data_i[rnsm_pkg::PitchW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.sine       = $signed(sine_q);
    cfg_o.cosine     = $signed(cosine_q);
    cfg_o.src_half_w = rnsm_pkg::dim_half(src_w_q);
    cfg_o.src_half_h = rnsm_pkg::dim_half(src_h_q);
    cfg_o.dst_half_w = rnsm_pkg::dim_half(dst_w_q);
    cfg_o.dst_half_h = rnsm_pkg::dim_half(dst_h_q);
    cfg_o.pitch      = pitch_q;
  end

endmodule
`default_nettype wire

FILE: design/rnsm_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnsm_rotate
// Three-stage centering and fixed-point rotation of a destination pixel.
// ----------------------------------------------------------------------------
module rnsm_rotate (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire rnsm_pkg::in_beat_t                 beat_i,
  input  wire rnsm_pkg::cfg_t                     cfg_i,
  output logic                                    valid_o,
  output logic signed [rnsm_pkg::SumW-1:0]        xs_o,
  output logic signed [rnsm_pkg::SumW-1:0]        ys_o
);

  localparam int DW = rnsm_pkg::DeltaW;
  localparam int PW = rnsm_pkg::ProdW;
  localparam int SW = rnsm_pkg::SumW;

  logic              v1_q, v2_q, v3_q;
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [PW-1:0] xc_d, ys_d, xsn_d, yc_d;
  logic signed [PW-1:0] xc_q, ysp_q, xsn_q, yc_q;
  logic signed [SW-1:0] sx_d, sy_d, sx_q, sy_q;

  // stage 1: center on destination
  assign dx_d = $signed({1'b0, beat_i.dest_col}) - $signed({1'b0, cfg_i.dst_half_w});
  assign dy_d = $signed({1'b0, beat_i.dest_row}) - $signed({1'b0, cfg_i.dst_half_h});

  // stage 2: four products
  assign xc_d  = dx_q * $signed(cfg_i.cosine);
  assign ys_d  = dy_q * $signed(cfg_i.sine);
  assign xsn_d = dx_q * $signed(cfg_i.sine);
  assign yc_d  = dy_q * $signed(cfg_i.cosine);

  // stage 3: rotated sums
  assign sx_d = SW'(xc_q) - SW'(ysp_q);
  assign sy_d = SW'(xsn_q) + SW'(yc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    xc_q  <= xc_d;
    ysp_q <= ys_d;
    xsn_q <= xsn_d;
    yc_q  <= yc_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
  end

  assign valid_o = v3_q;
  assign xs_o    = sx_q;
  assign ys_o    = sy_q;

endmodule
`default_nettype wire

FILE: design/rnsm_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnsm_map
// Scaling, bounds test and source byte offset, two register stages.
// ----------------------------------------------------------------------------
module rnsm_map (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic signed [rnsm_pkg::SumW-1:0] xs_i,
  input  wire logic signed [rnsm_pkg::SumW-1:0] ys_i,
  input  wire rnsm_pkg::cfg_t                 cfg_i,
  output logic                                valid_o,
  output rnsm_pkg::out_beat_t                 beat_o
);

  localparam int SW = rnsm_pkg::SumW;
  localparam int RW = rnsm_pkg::RotW;
  localparam int FB = rnsm_pkg::FRACTION_BITS;
  localparam int CW = rnsm_pkg::CoordW;
  localparam int OW = rnsm_pkg::OffsetW;
  localparam int MW = CW + rnsm_pkg::PitchW;

  logic signed [SW-1:0] xb, yb;
  logic signed [RW-1:0] xo, yo, xc, yc, xs_sum, ys_sum;
  logic                 inside_d, inside_q;
  logic [CW-1:0]        col_d, row_d, col_q, row_q;
  logic [MW-1:0]        offset_full;
  logic                 v4_q, v5_q;
  rnsm_pkg::out_beat_t  out_q;

  // truncate toward zero: bias negative sums before the shift
  assign xb = xs_i + $signed({{(SW-FB){1'b0}}, {FB{xs_i[SW-1]}}});
  assign yb = ys_i + $signed({{(SW-FB){1'b0}}, {FB{ys_i[SW-1]}}});
  assign xo = $signed(xb[SW-1:FB]);
  assign yo = $signed(yb[SW-1:FB]);
  assign xc = $signed({{(RW-CW){1'b0}}, cfg_i.src_half_w});
  assign yc = $signed({{(RW-CW){1'b0}}, cfg_i.src_half_h});

  assign xs_sum = xo + xc;
  assign ys_sum = yo + yc;

  assign inside_d = (xo >= -xc) && (xo < xc) && (yo >= -yc) && (yo < yc);
  assign col_d    = inside_d ? xs_sum[CW-1:0] : '0;
  assign row_d    = inside_d ? ys_sum[CW-1:0] : '0;

  assign offset_full = (MW'(row_q) * MW'(cfg_i.pitch)) + MW'({col_q, 2'b00});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q              <= inside_d;
    col_q                 <= col_d;
    row_q                 <= row_d;
    out_q.src_col         <= col_q;
    out_q.src_row         <= row_q;
    out_q.inside_res      <= inside_q;
    out_q.src_byte_offset <= offset_full[OW-1:0];
  end

  assign valid_o = v5_q;
  assign beat_o  = out_q;

endmodule
`default_nettype wire
